// File: sv/v3n_pkg.sv
// Shared constants and types for the vector normalize unit.
package v3n_pkg;

   localparam int COMP_WIDTH = 24;
   localparam int FRAC_BITS  = 16;
   localparam int UNIT_WIDTH = FRAC_BITS + 2;
   localparam int MAG_WIDTH  = COMP_WIDTH;
   localparam int SQ_WIDTH   = 2 * MAG_WIDTH;
   localparam int SUM_WIDTH  = SQ_WIDTH + 2;
   localparam int ROOT_WIDTH = SUM_WIDTH / 2;
   localparam int REM_WIDTH  = ROOT_WIDTH + 2;
   localparam int NUM_WIDTH  = MAG_WIDTH + FRAC_BITS;
   localparam int QUO_WIDTH  = FRAC_BITS + 1;
   localparam int DREM_WIDTH = COMP_WIDTH + 1;

   typedef logic [COMP_WIDTH-1:0] comp_type;
   typedef logic [MAG_WIDTH-1:0]  mag_type;
   typedef logic [SUM_WIDTH-1:0]  sum_type;
   typedef logic [ROOT_WIDTH-1:0] root_type;
   typedef logic [REM_WIDTH-1:0]  rem_type;
   typedef logic [NUM_WIDTH-1:0]  num_type;
   typedef logic [QUO_WIDTH-1:0]  quo_type;
   typedef logic [DREM_WIDTH-1:0] drem_type;

   // Data handed from one square-root cell to the next.
   typedef struct packed {
      logic     valid;
      sum_type  radicand;
      root_type root;
      rem_type  rem;
      mag_type  mag_x;
      mag_type  mag_y;
      mag_type  mag_z;
      logic     neg_x;
      logic     neg_y;
      logic     neg_z;
   } sqrt_token_type;

   // Data handed from one divider cell to the next.
   typedef struct packed {
      logic     valid;
      root_type divisor;
      num_type  num_x;
      num_type  num_y;
      num_type  num_z;
      drem_type rem_x;
      drem_type rem_y;
      drem_type rem_z;
      quo_type  quo_x;
      quo_type  quo_y;
      quo_type  quo_z;
      logic     neg_x;
      logic     neg_y;
      logic     neg_z;
   } div_token_type;

endpackage

// File: sv/v3n_if.sv
// Valid/ready channel interfaces for requests and responses.
interface v3n_req_if import v3n_pkg::*; ();
   logic     valid;
   logic     ready;
   comp_type in_x;
   comp_type in_y;
   comp_type in_z;
   modport source (output valid, in_x, in_y, in_z, input ready);
   modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

interface v3n_rsp_if import v3n_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [COMP_WIDTH-1:0]  vec_length;
   logic signed [UNIT_WIDTH-1:0] unit_x;
   logic signed [UNIT_WIDTH-1:0] unit_y;
   logic signed [UNIT_WIDTH-1:0] unit_z;
   logic                   zero_error;
   modport source (output valid, vec_length, unit_x, unit_y, unit_z, zero_error,
                   input ready);
   modport sink   (input valid, vec_length, unit_x, unit_y, unit_z, zero_error,
                   output ready);
endinterface

// File: sv/v3n_sqrt_cell.sv
// One restoring square-root cell: resolves one root bit per stage.
module v3n_sqrt_cell import v3n_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  sqrt_token_type tok_in,
   output sqrt_token_type tok_out
);
   sqrt_token_type tok_ff, tok_in_w;
   rem_type        rem_sh;
   rem_type        trial;

   always_comb begin
      tok_in_w = tok_in;
      rem_sh   = {tok_in.rem[REM_WIDTH-3:0], tok_in.radicand[SUM_WIDTH-1 -: 2]};
      trial    = {tok_in.root, 2'b01};
      tok_in_w.radicand = {tok_in.radicand[SUM_WIDTH-3:0], 2'b00};
      if (rem_sh >= trial) begin
         tok_in_w.rem  = rem_sh - trial;
         tok_in_w.root = {tok_in.root[ROOT_WIDTH-2:0], 1'b1};
      end else begin
         tok_in_w.rem  = rem_sh;
         tok_in_w.root = {tok_in.root[ROOT_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in_w;
      end
   end

   assign tok_out = tok_ff;
endmodule

// File: sv/v3n_div_cell.sv
// One restoring divider cell: resolves one quotient bit of each component.
module v3n_div_cell import v3n_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  div_token_type tok_in,
   output div_token_type tok_out
);
   div_token_type tok_ff, tok_in_w;

   function automatic void step(input drem_type r, input num_type n, input root_type d,
                                output drem_type r_o, output logic q);
      drem_type sh;
      sh = {r[DREM_WIDTH-2:0], n[NUM_WIDTH-1]};
      if (sh >= drem_type'(d)) begin
         r_o = sh - drem_type'(d);
         q   = 1'b1;
      end else begin
         r_o = sh;
         q   = 1'b0;
      end
   endfunction

   always_comb begin
      logic qx, qy, qz;
      tok_in_w = tok_in;
      step(tok_in.rem_x, tok_in.num_x, tok_in.divisor, tok_in_w.rem_x, qx);
      step(tok_in.rem_y, tok_in.num_y, tok_in.divisor, tok_in_w.rem_y, qy);
      step(tok_in.rem_z, tok_in.num_z, tok_in.divisor, tok_in_w.rem_z, qz);
      tok_in_w.num_x = {tok_in.num_x[NUM_WIDTH-2:0], 1'b0};
      tok_in_w.num_y = {tok_in.num_y[NUM_WIDTH-2:0], 1'b0};
      tok_in_w.num_z = {tok_in.num_z[NUM_WIDTH-2:0], 1'b0};
      tok_in_w.quo_x = {tok_in.quo_x[QUO_WIDTH-2:0], qx};
      tok_in_w.quo_y = {tok_in.quo_y[QUO_WIDTH-2:0], qy};
      tok_in_w.quo_z = {tok_in.quo_z[QUO_WIDTH-2:0], qz};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in_w;
      end
   end

   assign tok_out = tok_ff;
endmodule

// File: sv/vec3_normalize_unit.sv
// Vector normalize unit: squares, a chain of square-root cells, a chain of divider cells.
// Throughput: one request per cycle; every stage hands its data on
// each cycle, and the whole chain holds only while the output register is full and stalled.
// Reset: synchronous, active high; clears every valid bit, payload is left as is.
module vec3_normalize_unit import v3n_pkg::*; (
   input logic      clock,
   input logic      reset,
   v3n_req_if.sink   req,
   v3n_rsp_if.source rsp
);
   // The pipeline advances whenever the output register is free or being drained.
   logic advance;
   logic out_valid_ff;
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   // Stage 1: magnitudes and signs.
   mag_type mag_x_ff, mag_y_ff, mag_z_ff;
   logic    neg_x_ff, neg_y_ff, neg_z_ff, s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req.valid;
         neg_x_ff <= req.in_x[COMP_WIDTH-1];
         neg_y_ff <= req.in_y[COMP_WIDTH-1];
         neg_z_ff <= req.in_z[COMP_WIDTH-1];
         mag_x_ff <= req.in_x[COMP_WIDTH-1] ? mag_type'(-req.in_x) : mag_type'(req.in_x);
         mag_y_ff <= req.in_y[COMP_WIDTH-1] ? mag_type'(-req.in_y) : mag_type'(req.in_y);
         mag_z_ff <= req.in_z[COMP_WIDTH-1] ? mag_type'(-req.in_z) : mag_type'(req.in_z);
      end
   end

   // Stage 2: square the magnitudes, one multiplier each, registered.
   logic [SQ_WIDTH-1:0] sq_x_ff, sq_y_ff, sq_z_ff;
   mag_type m2_x_ff, m2_y_ff, m2_z_ff;
   logic    n2_x_ff, n2_y_ff, n2_z_ff, s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
         sq_x_ff <= mag_x_ff * mag_x_ff;
         sq_y_ff <= mag_y_ff * mag_y_ff;
         sq_z_ff <= mag_z_ff * mag_z_ff;
         m2_x_ff <= mag_x_ff; m2_y_ff <= mag_y_ff; m2_z_ff <= mag_z_ff;
         n2_x_ff <= neg_x_ff; n2_y_ff <= neg_y_ff; n2_z_ff <= neg_z_ff;
      end
   end

   // Sum feeds the head of the square-root chain.
   sqrt_token_type sq_chain [ROOT_WIDTH+1];

   always_comb begin
      sq_chain[0].valid    = s2_valid_ff;
      sq_chain[0].radicand = sum_type'(sq_x_ff) + sum_type'(sq_y_ff) + sum_type'(sq_z_ff);
      sq_chain[0].root     = '0;
      sq_chain[0].rem      = '0;
      sq_chain[0].mag_x    = m2_x_ff;
      sq_chain[0].mag_y    = m2_y_ff;
      sq_chain[0].mag_z    = m2_z_ff;
      sq_chain[0].neg_x    = n2_x_ff;
      sq_chain[0].neg_y    = n2_y_ff;
      sq_chain[0].neg_z    = n2_z_ff;
   end

   for (genvar i = 0; i < ROOT_WIDTH; i++) begin : g_sqrt
      v3n_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (sq_chain[i]),
         .tok_out (sq_chain[i+1])
      );
   end

   // Hand the root and scaled magnitudes to the divider chain.
   div_token_type dv_chain [NUM_WIDTH+1];
   sqrt_token_type sq_last;
   assign sq_last = sq_chain[ROOT_WIDTH];

   always_comb begin
      dv_chain[0].valid   = sq_last.valid;
      dv_chain[0].divisor = sq_last.root;
      dv_chain[0].num_x   = {sq_last.mag_x, FRAC_BITS'(0)};
      dv_chain[0].num_y   = {sq_last.mag_y, FRAC_BITS'(0)};
      dv_chain[0].num_z   = {sq_last.mag_z, FRAC_BITS'(0)};
      dv_chain[0].rem_x   = '0;
      dv_chain[0].rem_y   = '0;
      dv_chain[0].rem_z   = '0;
      dv_chain[0].quo_x   = '0;
      dv_chain[0].quo_y   = '0;
      dv_chain[0].quo_z   = '0;
      dv_chain[0].neg_x   = sq_last.neg_x;
      dv_chain[0].neg_y   = sq_last.neg_y;
      dv_chain[0].neg_z   = sq_last.neg_z;
   end

   for (genvar j = 0; j < NUM_WIDTH; j++) begin : g_div
      v3n_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_in  (dv_chain[j]),
         .tok_out (dv_chain[j+1])
      );
   end

   // Output register: apply signs, flag a zero length.
   div_token_type dv_last;
   logic zero_len;
   assign dv_last  = dv_chain[NUM_WIDTH];
   assign zero_len = (dv_last.divisor == '0);

   logic [COMP_WIDTH-1:0]        len_ff;
   logic signed [UNIT_WIDTH-1:0] ux_ff, uy_ff, uz_ff;
   logic                         zerr_ff;

   function automatic logic [UNIT_WIDTH-1:0] apply_sign(input quo_type q, input logic n,
                                                        input logic z);
      logic [UNIT_WIDTH-1:0] w;
      w = {1'b0, q};
      if (z) return '0;
      return n ? -w : w;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv_last.valid;
         len_ff  <= dv_last.divisor[COMP_WIDTH-1:0];
         zerr_ff <= zero_len;
         ux_ff   <= apply_sign(dv_last.quo_x, dv_last.neg_x, zero_len);
         uy_ff   <= apply_sign(dv_last.quo_y, dv_last.neg_y, zero_len);
         uz_ff   <= apply_sign(dv_last.quo_z, dv_last.neg_z, zero_len);
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.vec_length = len_ff;
   assign rsp.unit_x     = ux_ff;
   assign rsp.unit_y     = uy_ff;
   assign rsp.unit_z     = uz_ff;
   assign rsp.zero_error = zerr_ff;
endmodule

// File: verif/vec3_normalize_unit_test.sv
// Testbench for the vector normalize unit: random and corner vectors against a built-in predictor.
module vec3_normalize_unit_test;
   import v3n_pkg::*;

   // Expected response fields, in request order.
   typedef struct {
      logic [COMP_WIDTH-1:0]        vec_length;
      logic signed [UNIT_WIDTH-1:0] unit_x;
      logic signed [UNIT_WIDTH-1:0] unit_y;
      logic signed [UNIT_WIDTH-1:0] unit_z;
      logic                         zero_error;
   } norm_result_type;

   typedef struct {
      comp_type x;
      comp_type y;
      comp_type z;
   } vec_req_type;

   localparam int LATENCY     = 2 + ROOT_WIDTH + NUM_WIDTH + 1;
   localparam int CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;

   v3n_req_if req_ch ();
   v3n_rsp_if rsp_ch ();

   vec3_normalize_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   vec_req_type     pending_vecs[$];
   norm_result_type expected_norms[$];
   int              error_count;
   int              cycle_count;
   int              sent_count;
   int              checked_count;
   int              zero_count;
   bit              stimulus_loaded;
   bit              idle_free;      // long stretch with no gaps on either side

   // Floor square root, bit by bit.
   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_val;
      res = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val >>= 2;
      while (bit_val != 0) begin
         if (v >= res + bit_val) begin
            v -= res + bit_val;
            res = (res >> 1) + bit_val;
         end else begin
            res >>= 1;
         end
         bit_val >>= 2;
      end
      return res;
   endfunction

   // Compute length and unit vector for one request.
   function automatic norm_result_type normalize_vec(vec_req_type v);
      norm_result_type r;
      logic [63:0]  mag[3];
      logic         neg[3];
      logic [63:0]  sum;
      logic [63:0]  len;
      logic [63:0]  quo;
      comp_type     comp[3];
      comp = '{v.x, v.y, v.z};
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = comp[i][COMP_WIDTH-1];
         mag[i] = neg[i] ? (64'd1 << COMP_WIDTH) - 64'(comp[i]) : 64'(comp[i]);
         sum += mag[i] * mag[i];
      end
      len = floor_root(sum);
      r.vec_length = len[COMP_WIDTH-1:0];
      r.unit_x = '0;
      r.unit_y = '0;
      r.unit_z = '0;
      r.zero_error = (len == 0);
      if (len != 0) begin
         for (int i = 0; i < 3; i++) begin
            quo = (mag[i] << FRAC_BITS) / len;
            if (neg[i]) quo = 64'd0 - quo;
            case (i)
               0: r.unit_x = quo[UNIT_WIDTH-1:0];
               1: r.unit_y = quo[UNIT_WIDTH-1:0];
               default: r.unit_z = quo[UNIT_WIDTH-1:0];
            endcase
         end
      end
      return r;
   endfunction

   function automatic comp_type rand_comp();
      case ($urandom_range(0, 9))
         0: return comp_type'($urandom_range(0, 3)) - comp_type'(2);      // around zero
         1: return comp_type'({1'b1, {(COMP_WIDTH-1){1'b0}}} + $urandom_range(0, 2));
         2: return comp_type'({1'b0, {(COMP_WIDTH-1){1'b1}}} - $urandom_range(0, 2));
         3: return comp_type'($urandom_range(0, 255)) - comp_type'(128);  // tiny lengths
         default: return comp_type'($urandom);
      endcase
   endfunction

   function automatic void queue_vec(comp_type x, comp_type y, comp_type z);
      vec_req_type v;
      v.x = x;
      v.y = y;
      v.z = z;
      pending_vecs.push_back(v);
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hold reset, then release it and fill the request queue.
   initial begin
      comp_type max_pos;
      comp_type max_neg;
      max_pos = {1'b0, {(COMP_WIDTH-1){1'b1}}};
      max_neg = {1'b1, {(COMP_WIDTH-1){1'b0}}};
      reset = 1'b1;
      stimulus_loaded = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // Directed corners: zero vector, axis extremes, all-max, all-min, tiny values.
      queue_vec(0, 0, 0);
      queue_vec(max_pos, 0, 0);
      queue_vec(0, max_neg, 0);
      queue_vec(0, 0, max_neg);
      queue_vec(max_pos, max_pos, max_pos);
      queue_vec(max_neg, max_neg, max_neg);
      queue_vec(max_neg, max_pos, max_neg);
      queue_vec(1, 0, 0);
      queue_vec(0, comp_type'(-1), 0);
      queue_vec(1, 1, 1);
      queue_vec(comp_type'(-1), comp_type'(-1), comp_type'(-1));
      queue_vec(24'h010000, 24'h010000, 24'h010000);
      queue_vec(24'h030000, 24'hFC0000, 0);
      queue_vec(0, 0, 0);
      queue_vec(24'h555555, 24'hAAAAAA, 24'h5A5A5A);
      for (int i = 0; i < 650; i++) queue_vec(rand_comp(), rand_comp(), rand_comp());
      stimulus_loaded = 1'b1;
   end

   // Drop the idling odds to zero for a long window in the middle of the run.
   always @(posedge clock) idle_free <= (cycle_count > 300 && cycle_count < 700);

   // Driver: advance to the next request once the current one is accepted.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.in_x  <= '0;
         req_ch.in_y  <= '0;
         req_ch.in_z  <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (pending_vecs.size() > 0 && (idle_free || $urandom_range(0, 99) >= 9)) begin
            vec_req_type v;
            v = pending_vecs.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.in_x  <= v.x;
            req_ch.in_y  <= v.y;
            req_ch.in_z  <= v.z;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response stall: ready is low about 9 percent of the time outside the free window.
   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= idle_free || ($urandom_range(0, 99) >= 9);
   end

   // Monitor: predict on each accepted request, check each accepted response.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            vec_req_type v;
            v.x = req_ch.in_x;
            v.y = req_ch.in_y;
            v.z = req_ch.in_z;
            expected_norms.push_back(normalize_vec(v));
            sent_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_norms.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               norm_result_type e;
               e = expected_norms.pop_front();
               checked_count++;
               if (e.zero_error) zero_count++;
               if (rsp_ch.vec_length !== e.vec_length) begin
                  $error("vec_length: expected %0d, got %0d", e.vec_length, rsp_ch.vec_length);
                  error_count++;
               end
               if (rsp_ch.unit_x !== e.unit_x) begin
                  $error("unit_x: expected %0d, got %0d", e.unit_x, rsp_ch.unit_x);
                  error_count++;
               end
               if (rsp_ch.unit_y !== e.unit_y) begin
                  $error("unit_y: expected %0d, got %0d", e.unit_y, rsp_ch.unit_y);
                  error_count++;
               end
               if (rsp_ch.unit_z !== e.unit_z) begin
                  $error("unit_z: expected %0d, got %0d", e.unit_z, rsp_ch.unit_z);
                  error_count++;
               end
               if (rsp_ch.zero_error !== e.zero_error) begin
                  $error("zero_error: expected %0d, got %0d", e.zero_error, rsp_ch.zero_error);
                  error_count++;
               end
            end
         end
      end
   end

   // Cycle counter with a hard timeout.
   initial begin
      cycle_count = 0;
      error_count = 0;
      sent_count = 0;
      checked_count = 0;
      zero_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("vec3_normalize_unit_test: errors");
      $finish;
   end

   // Wait for the queue to drain and every response to arrive, then report.
   initial begin
      wait (stimulus_loaded);
      wait (pending_vecs.size() == 0 && !req_ch.valid);
      wait (expected_norms.size() == 0);
      repeat (2 * LATENCY) @(posedge clock);
      $display("covered %0d vectors, %0d checked, %0d zero-length", sent_count,
               checked_count, zero_count);
      if (error_count == 0 && expected_norms.size() == 0) begin
         $display("vec3_normalize_unit_test: clean");
      end else begin
         $display("vec3_normalize_unit_test: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/v3n_pkg.sv
sv/v3n_if.sv
sv/v3n_sqrt_cell.sv
sv/v3n_div_cell.sv
sv/vec3_normalize_unit.sv
verif/vec3_normalize_unit_test.sv
